// File: hw/rtl/grc_pkg.sv
// shared types, widths, register indexes and reset values for the gyro
// revolution counter; no dependencies
`default_nettype none

package grc_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;

   localparam int SAMPLE_W   = 16;
   localparam int MAG_W      = 17;
   localparam int ACC_W      = 22;
   localparam int DEADBAND_W = 15;
   localparam int TURN_W     = 20;
   localparam int HOLD_W     = 10;
   localparam int LED_IDX_W  = 3;
   localparam int LED_W      = 4;
   localparam int EVENT_W    = 2;
   localparam int RESULT_W   = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // turn event codes
   localparam logic [EVENT_W-1:0] EVENT_NONE = 2'd0;
   localparam logic [EVENT_W-1:0] EVENT_FWD  = 2'd1;
   localparam logic [EVENT_W-1:0] EVENT_BWD  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_UNITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LED_HOLD   = 2'd2;

   // register reset values
   localparam logic [DEADBAND_W-1:0] DEADBAND_RESET   = 15'd128;
   localparam logic [TURN_W-1:0]     TURN_UNITS_RESET = 20'd589824;
   localparam logic [HOLD_W-1:0]     LED_HOLD_RESET   = 10'd300;

   // chase positions
   localparam logic [LED_IDX_W-1:0] LED_DARK  = 3'd0;
   localparam logic [LED_IDX_W-1:0] LED_FIRST = 3'd1;
   localparam logic [LED_IDX_W-1:0] LED_LAST  = 3'd4;

   typedef struct packed {
      logic fwd;
      logic bwd;
   } turn_type;

   typedef struct packed {
      logic [DEADBAND_W-1:0] deadband;
      logic [TURN_W-1:0]     turn_units;
      logic [HOLD_W-1:0]     led_hold;
   } cfg_type;

endpackage

`default_nettype wire

// File: hw/rtl/grc_csr.sv
// configuration registers: deadband, turn size and led hold time
// depends on grc_pkg
`default_nettype none

module grc_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   input  wire logic [grc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [grc_pkg::CSR_DATA_W-1:0] csr_data,
   output grc_pkg::cfg_type                    cfg
);

   grc_pkg::cfg_type cfg_ff;
   grc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            grc_pkg::CSR_DEADBAND:   cfg_in.deadband   = csr_data[grc_pkg::DEADBAND_W-1:0];
            grc_pkg::CSR_TURN_UNITS: cfg_in.turn_units = csr_data[grc_pkg::TURN_W-1:0];
            grc_pkg::CSR_LED_HOLD:   cfg_in.led_hold   = csr_data[grc_pkg::HOLD_W-1:0];
            default:                 cfg_in = cfg_ff; // unused index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadband   <= grc_pkg::DEADBAND_RESET;
         cfg_ff.turn_units <= grc_pkg::TURN_UNITS_RESET;
         cfg_ff.led_hold   <= grc_pkg::LED_HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: hw/rtl/grc_angle.sv
// angle accumulator with deadband and turn detection
// depends on grc_pkg
`default_nettype none

module grc_angle (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 step,
   input  wire logic signed [grc_pkg::SAMPLE_W-1:0]  sample,
   input  wire logic        [grc_pkg::DEADBAND_W-1:0] deadband,
   input  wire logic        [grc_pkg::TURN_W-1:0]     turn_units,
   output grc_pkg::turn_type                         turn
);

   logic signed [grc_pkg::ACC_W-1:0] acc_ff;
   logic signed [grc_pkg::ACC_W-1:0] acc_in;

   logic signed [grc_pkg::MAG_W-1:0] sample_wide;
   logic        [grc_pkg::MAG_W-1:0] mag;
   logic                             pass;
   logic signed [grc_pkg::ACC_W-1:0] sum;
   logic signed [grc_pkg::ACC_W-1:0] acc_a;
   logic signed [grc_pkg::ACC_W-1:0] turn_acc;
   logic signed [grc_pkg::ACC_W:0]   acc_cmp;
   logic signed [grc_pkg::ACC_W:0]   turn_cmp;
   logic                             over;
   logic                             under;

   always_comb begin
      sample_wide = grc_pkg::MAG_W'(sample);
      mag         = sample[grc_pkg::SAMPLE_W-1] ? unsigned'(-sample_wide)
                                                 : unsigned'(sample_wide);
      pass        = mag > grc_pkg::MAG_W'(deadband);
      sum         = acc_ff + grc_pkg::ACC_W'(sample);
      acc_a       = pass ? sum : acc_ff;
      turn_acc    = signed'(grc_pkg::ACC_W'(turn_units));
      acc_cmp     = (grc_pkg::ACC_W+1)'(acc_a);
      turn_cmp    = signed'((grc_pkg::ACC_W+1)'(turn_units));
      over        = acc_cmp > turn_cmp;
      under       = acc_cmp < -turn_cmp;
      priority if (over) begin
         acc_in = acc_a - turn_acc;
      end else if (under) begin
         acc_in = acc_a + turn_acc;
      end else begin
         acc_in = acc_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (step) begin
         acc_ff <= acc_in;
      end
   end

   assign turn.fwd = over;
   assign turn.bwd = !over && under;

endmodule

`default_nettype wire

// File: hw/rtl/grc_chase.sv
// four-led one-hot chase with hold timer
// depends on grc_pkg
`default_nettype none

module grc_chase (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire grc_pkg::turn_type             turn,
   input  wire logic [grc_pkg::HOLD_W-1:0]    led_hold,
   output logic      [grc_pkg::LED_W-1:0]     pattern
);

   logic [grc_pkg::LED_IDX_W-1:0] idx_ff;
   logic [grc_pkg::LED_IDX_W-1:0] idx_in;
   logic [grc_pkg::HOLD_W-1:0]    hold_ff;
   logic [grc_pkg::HOLD_W-1:0]    hold_in;
   logic [grc_pkg::LED_IDX_W-1:0] idx_t;
   logic [grc_pkg::HOLD_W-1:0]    hold_t;
   logic [1:0]                    pos;

   always_comb begin
      idx_t  = idx_ff;
      hold_t = hold_ff;
      if (turn.fwd) begin
         idx_t  = (idx_ff >= grc_pkg::LED_LAST) ? grc_pkg::LED_FIRST
                                                 : idx_ff + grc_pkg::LED_IDX_W'(1);
         hold_t = led_hold;
      end else if (turn.bwd) begin
         idx_t  = (idx_ff <= grc_pkg::LED_FIRST) ? grc_pkg::LED_LAST
                                                  : idx_ff - grc_pkg::LED_IDX_W'(1);
         hold_t = led_hold;
      end

      idx_in  = idx_t;
      hold_in = hold_t;
      pattern = '0;
      pos     = 2'(idx_t - grc_pkg::LED_FIRST);
      if (idx_t != grc_pkg::LED_DARK) begin
         if (hold_t == '0) begin
            idx_in = grc_pkg::LED_DARK;
         end else begin
            hold_in = hold_t - grc_pkg::HOLD_W'(1);
            pattern = grc_pkg::LED_W'(1) << pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= grc_pkg::LED_DARK;
         hold_ff <= '0;
      end else if (step) begin
         idx_ff  <= idx_in;
         hold_ff <= hold_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/gyro_revolution_counter.sv
// top level of the gyro revolution counter: input register, update logic,
// result register; depends on grc_pkg, grc_csr, grc_angle and grc_chase
`default_nettype none

// usage
//  req channel: one signed rate sample per item (req_rate_sample)
//  rsp channel: one result per sample - net revolution count, turn event
//    (none / forward / backward) and the led chase pattern for that tick
//  csr channel: writes deadband, turn size and led hold; always ready,
//    only to be written while no item is in flight; unused indexes ignored
//  flow: an accepted item waits in the input register, and its result is
//    registered in the result register once that is free or being emptied
//  throughput: one item per cycle while rsp_ready is high; accumulator, count
//    and chase update combinationally between input and result register
//  stall: while rsp_ready is low the result holds; the input register
//    takes one more item, then req_ready drops until the result is taken
//  reset (synchronous): accumulator, count and chase cleared, chase dark,
//    registers back to their defaults, both register stages empty
//  revolution count is COUNT_WIDTH bits inside, sign-extended or cut to
//  the 32-bit result field

module gyro_revolution_counter #(
   parameter int COUNT_WIDTH = grc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input samples
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [grc_pkg::SAMPLE_W-1:0]  req_rate_sample,
   // results
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [grc_pkg::RESULT_W-1:0]       rsp_revolution_count,
   output logic        [grc_pkg::EVENT_W-1:0]        rsp_turn_event,
   output logic        [grc_pkg::LED_W-1:0]          rsp_led_pattern,
   // configuration
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [grc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [grc_pkg::CSR_DATA_W-1:0]       csr_data
);

   // input register
   logic                                in_valid_ff;
   logic signed [grc_pkg::SAMPLE_W-1:0] sample_ff;

   // result register
   logic                                rsp_valid_ff;
   logic signed [grc_pkg::RESULT_W-1:0] rsp_count_ff;
   logic [grc_pkg::EVENT_W-1:0]         rsp_event_ff;
   logic [grc_pkg::LED_W-1:0]           rsp_pattern_ff;

   // revolution count
   logic [COUNT_WIDTH-1:0]              count_ff;
   logic [COUNT_WIDTH-1:0]              count_in;
   logic [grc_pkg::RESULT_W-1:0]        count_out;

   logic                                step;
   grc_pkg::cfg_type                    cfg;
   grc_pkg::turn_type                   turn;
   logic [grc_pkg::LED_W-1:0]           pattern;
   logic [grc_pkg::EVENT_W-1:0]         event_code;

   // the held item moves on when the result register is free or being emptied
   assign step      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign csr_ready = 1'b1;

   grc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   grc_angle u_angle (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .sample     (sample_ff),
      .deadband   (cfg.deadband),
      .turn_units (cfg.turn_units),
      .turn       (turn)
   );

   grc_chase u_chase (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .turn     (turn),
      .led_hold (cfg.led_hold),
      .pattern  (pattern)
   );

   // count update, wraps at COUNT_WIDTH bits
   always_comb begin
      priority if (turn.fwd) begin
         count_in   = count_ff + COUNT_WIDTH'(1);
         event_code = grc_pkg::EVENT_FWD;
      end else if (turn.bwd) begin
         count_in   = count_ff - COUNT_WIDTH'(1);
         event_code = grc_pkg::EVENT_BWD;
      end else begin
         count_in   = count_ff;
         event_code = grc_pkg::EVENT_NONE;
      end
   end

   // fit the internal count into the 32-bit result field
   generate
      if (COUNT_WIDTH >= grc_pkg::RESULT_W) begin : g_cut
         assign count_out = count_in[grc_pkg::RESULT_W-1:0];
      end else begin : g_extend
         assign count_out = {{(grc_pkg::RESULT_W-COUNT_WIDTH){count_in[COUNT_WIDTH-1]}},
                             count_in};
      end
   endgenerate

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (step) begin
            in_valid_ff <= 1'b0;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
            count_ff     <= count_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         sample_ff <= req_rate_sample;
      end
      if (step) begin
         rsp_count_ff   <= signed'(count_out);
         rsp_event_ff   <= event_code;
         rsp_pattern_ff <= pattern;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_revolution_count = rsp_count_ff;
   assign rsp_turn_event       = rsp_event_ff;
   assign rsp_led_pattern      = rsp_pattern_ff;

endmodule

`default_nettype wire

// File: hw/rtl/grc_checker.sv
// port-level checks for the gyro revolution counter, bound to the top level
// depends on grc_pkg and gyro_revolution_counter
`default_nettype none

module grc_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [grc_pkg::RESULT_W-1:0]   rsp_revolution_count,
   input wire logic [grc_pkg::EVENT_W-1:0]    rsp_turn_event,
   input wire logic [grc_pkg::LED_W-1:0]      rsp_led_pattern
);

   logic                         seen_ff;
   logic [grc_pkg::RESULT_W-1:0] last_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         seen_ff <= 1'b1;
      end
      if (rsp_valid && rsp_ready) begin
         last_count_ff <= rsp_revolution_count;
      end
   end

   // results are empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_revolution_count)
         && $stable(rsp_turn_event) && $stable(rsp_led_pattern)))
      else $error("stalled result changed");

   // only defined event codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_turn_event == grc_pkg::EVENT_NONE
         || rsp_turn_event == grc_pkg::EVENT_FWD || rsp_turn_event == grc_pkg::EVENT_BWD))
      else $error("undefined turn event");

   // at most one led lit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_led_pattern))
      else $error("more than one led lit");

   // the count moves only on a turn
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && seen_ff && rsp_turn_event == grc_pkg::EVENT_NONE)
         |-> rsp_revolution_count == last_count_ff)
      else $error("count changed without a turn");

endmodule

bind gyro_revolution_counter grc_checker u_grc_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_revolution_count (rsp_revolution_count),
   .rsp_turn_event       (rsp_turn_event),
   .rsp_led_pattern      (rsp_led_pattern)
);

`default_nettype wire

// File: test/tb_gyro_revolution_counter.sv
`timescale 1ns / 1ps
// self-checking testbench for gyro_revolution_counter: directed plan, then random
// sample streams over several register settings; depends on grc_pkg and the rtl

module tb_gyro_revolution_counter;

   // watchdog: cycles in a row with no handshake on any channel
   localparam int STALL_LIMIT = 2000;
   // items per random phase, nine phases in all
   localparam int PHASE_ITEMS = 145;
   localparam int PHASES      = 9;
   // index with no register behind it, writes there must change nothing
   localparam logic [grc_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // one result item as the block reports it
   typedef struct packed {
      logic signed [grc_pkg::RESULT_W-1:0] revs;
      logic [grc_pkg::EVENT_W-1:0]         turn;
      logic [grc_pkg::LED_W-1:0]           leds;
   } tick_result_type;

   // directed plan rows: a sample checked by the model, a sample with its
   // result written out by hand, or a register write
   typedef enum logic [1:0] {STEP_PREDICT, STEP_TYPED, STEP_WRITE} step_kind_type;

   typedef struct packed {
      step_kind_type                        kind;
      logic [grc_pkg::CSR_IDX_W-1:0]        index;
      logic [grc_pkg::CSR_DATA_W-1:0]       data;
      logic signed [grc_pkg::SAMPLE_W-1:0]  rate;
      tick_result_type                      want;
   } plan_row_type;

   localparam tick_result_type QUIET = '{32'sd0, grc_pkg::EVENT_NONE, 4'b0000};

   localparam int PLAN_ROWS = 32;
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      // reset settings: deadband 128, a turn far away, nothing moves
      '{STEP_TYPED,   grc_pkg::CSR_DEADBAND,   20'd0,     16'sd0,     QUIET},
      '{STEP_TYPED,   grc_pkg::CSR_DEADBAND,   20'd0,     16'sd128,   QUIET}, // on the deadband
      '{STEP_TYPED,   grc_pkg::CSR_DEADBAND,   20'd0,     -16'sd128,  QUIET},
      '{STEP_TYPED,   grc_pkg::CSR_DEADBAND,   20'd0,     16'sd129,   QUIET}, // just past it
      '{STEP_TYPED,   grc_pkg::CSR_DEADBAND,   20'd0,     16'sh8000,  QUIET}, // most negative
      '{STEP_TYPED,   grc_pkg::CSR_DEADBAND,   20'd0,     16'sh7FFF,  QUIET}, // angle now 128
      // smallest turn, no deadband, chase lit for one tick
      '{STEP_WRITE,   grc_pkg::CSR_DEADBAND,   20'd0,     16'sd0,     QUIET},
      '{STEP_WRITE,   grc_pkg::CSR_TURN_UNITS, 20'd32768, 16'sd0,     QUIET},
      '{STEP_WRITE,   grc_pkg::CSR_LED_HOLD,   20'd1,     16'sd0,     QUIET},
      '{STEP_TYPED,   grc_pkg::CSR_DEADBAND,   20'd0,     16'sh7FFF,
        '{32'sd1, grc_pkg::EVENT_FWD, 4'b0001}},                        // red from dark
      '{STEP_TYPED,   grc_pkg::CSR_DEADBAND,   20'd0,     16'sd0,
        '{32'sd1, grc_pkg::EVENT_NONE, 4'b0000}},                       // hold ran out
      '{STEP_TYPED,   grc_pkg::CSR_DEADBAND,   20'd0,     16'sh8000,
        '{32'sd1, grc_pkg::EVENT_NONE, 4'b0000}},
      '{STEP_TYPED,   grc_pkg::CSR_DEADBAND,   20'd0,     -16'sd128,
        '{32'sd0, grc_pkg::EVENT_BWD, 4'b1000}},                        // blue from dark
      '{STEP_TYPED,   grc_pkg::CSR_DEADBAND,   20'd0,     16'sh8000,
        '{-32'sd1, grc_pkg::EVENT_BWD, 4'b0100}},                       // count below zero
      '{STEP_TYPED,   grc_pkg::CSR_DEADBAND,   20'd0,     16'sd1,
        '{-32'sd1, grc_pkg::EVENT_NONE, 4'b0000}},
      // widest deadband: only the most negative sample gets through
      '{STEP_WRITE,   grc_pkg::CSR_LED_HOLD,   20'd1023,  16'sd0,     QUIET},
      '{STEP_WRITE,   grc_pkg::CSR_DEADBAND,   20'd32767, 16'sd0,     QUIET},
      '{STEP_TYPED,   grc_pkg::CSR_DEADBAND,   20'd0,     16'sh7FFF,
        '{-32'sd1, grc_pkg::EVENT_NONE, 4'b0000}},
      '{STEP_TYPED,   grc_pkg::CSR_DEADBAND,   20'd0,     16'sh8000,
        '{-32'sd1, grc_pkg::EVENT_NONE, 4'b0000}},                      // exactly one turn back
      '{STEP_TYPED,   grc_pkg::CSR_DEADBAND,   20'd0,     16'sh8000,
        '{-32'sd2, grc_pkg::EVENT_BWD, 4'b1000}},
      // forward turns on almost every tick, chase wraps from blue to red
      '{STEP_WRITE,   grc_pkg::CSR_DEADBAND,   20'd0,     16'sd0,     QUIET},
      '{STEP_PREDICT, grc_pkg::CSR_DEADBAND,   20'd0,     16'sh7FFF,  QUIET},
      '{STEP_PREDICT, grc_pkg::CSR_DEADBAND,   20'd0,     16'sh7FFF,  QUIET},
      '{STEP_PREDICT, grc_pkg::CSR_DEADBAND,   20'd0,     16'sh7FFF,  QUIET},
      '{STEP_PREDICT, grc_pkg::CSR_DEADBAND,   20'd0,     16'sh7FFF,  QUIET},
      '{STEP_PREDICT, grc_pkg::CSR_DEADBAND,   20'd0,     16'sh7FFF,  QUIET},
      '{STEP_PREDICT, grc_pkg::CSR_DEADBAND,   20'd0,     16'sh7FFF,  QUIET},
      // unused index, then the largest turn with no hold at all
      '{STEP_WRITE,   CSR_UNUSED,              20'hFFFFF, 16'sd0,     QUIET},
      '{STEP_WRITE,   grc_pkg::CSR_TURN_UNITS, 20'hFFFFF, 16'sd0,     QUIET},
      '{STEP_WRITE,   grc_pkg::CSR_LED_HOLD,   20'd0,     16'sd0,     QUIET},
      '{STEP_PREDICT, grc_pkg::CSR_DEADBAND,   20'd0,     16'sh7FFF,  QUIET},
      '{STEP_PREDICT, grc_pkg::CSR_DEADBAND,   20'd0,     16'sh8001,  QUIET}
   };

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic signed [grc_pkg::SAMPLE_W-1:0] req_rate_sample;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic signed [grc_pkg::RESULT_W-1:0] rsp_revolution_count;
   logic [grc_pkg::EVENT_W-1:0]         rsp_turn_event;
   logic [grc_pkg::LED_W-1:0]           rsp_led_pattern;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [grc_pkg::CSR_IDX_W-1:0]       csr_index;
   logic [grc_pkg::CSR_DATA_W-1:0]      csr_data;

   gyro_revolution_counter dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_rate_sample      (req_rate_sample),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_revolution_count (rsp_revolution_count),
      .rsp_turn_event       (rsp_turn_event),
      .rsp_led_pattern      (rsp_led_pattern),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   // our own copy of the counter: registers, accumulator, count and chase
   grc_pkg::cfg_type                    settings;
   logic signed [grc_pkg::ACC_W-1:0]    angle_units;
   logic [grc_pkg::RESULT_W-1:0]        revs_net;
   logic [grc_pkg::LED_IDX_W-1:0]       chase_pos;
   logic [grc_pkg::HOLD_W-1:0]          hold_ticks;

   // results still owed by the block, oldest first
   tick_result_type             awaited_results [$];

   // idling of both sides; a calm count gives stretches with no idling
   int                          tx_idle_pct;
   int                          rx_idle_pct;
   int                          tx_calm;
   int                          rx_calm;

   int                          mismatches;
   int                          samples_sent;
   int                          results_seen;
   int                          writes_done;
   int                          fwd_turns;
   int                          bwd_turns;

   tick_result_type             seen;
   tick_result_type             want;

   // free-running clock, 8 ns period
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // one tick of the counter for an accepted sample: deadband, accumulate,
   // at most one turn either way, then the chase and its hold timer
   function automatic tick_result_type advance_revolutions(
      input logic signed [grc_pkg::SAMPLE_W-1:0] rate);
      int                               mag;
      int                               span;
      logic signed [grc_pkg::ACC_W-1:0] acc;
      tick_result_type                  r;
      mag  = (rate < 0) ? -int'(rate) : int'(rate);
      span = int'(settings.turn_units);
      acc  = angle_units;
      r    = QUIET;
      if (mag > int'(settings.deadband))
         acc = acc + grc_pkg::ACC_W'(rate);       // wraps at the accumulator width
      if (int'(acc) > span) begin
         acc = acc - grc_pkg::ACC_W'(span);
         revs_net = revs_net + grc_pkg::RESULT_W'(1);
         r.turn = grc_pkg::EVENT_FWD;
         chase_pos = (chase_pos >= grc_pkg::LED_LAST) ? grc_pkg::LED_FIRST
                                                       : chase_pos + grc_pkg::LED_IDX_W'(1);
         hold_ticks = settings.led_hold;
      end else if (int'(acc) < -span) begin
         acc = acc + grc_pkg::ACC_W'(span);
         revs_net = revs_net - grc_pkg::RESULT_W'(1);
         r.turn = grc_pkg::EVENT_BWD;
         chase_pos = (chase_pos <= grc_pkg::LED_FIRST) ? grc_pkg::LED_LAST
                                                        : chase_pos - grc_pkg::LED_IDX_W'(1);
         hold_ticks = settings.led_hold;
      end
      angle_units = acc;
      // a lit chase with no hold left goes dark on this very tick
      if (chase_pos != grc_pkg::LED_DARK) begin
         if (hold_ticks == '0)
            chase_pos = grc_pkg::LED_DARK;
         else begin
            hold_ticks = hold_ticks - grc_pkg::HOLD_W'(1);
            r.leds = grc_pkg::LED_W'(1) << (chase_pos - grc_pkg::LED_FIRST);
         end
      end
      r.revs = signed'(revs_net);
      return r;
   endfunction

   function automatic void set_idling(input int mode);
      case (mode)
         0: begin
            tx_idle_pct = 28;
            rx_idle_pct = 85;
         end
         1: begin
            tx_idle_pct = 85;
            rx_idle_pct = 28;
         end
         default: begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
      endcase
   endfunction

   // present one sample, hold it until taken, then book what it should give
   task automatic send_sample(input logic signed [grc_pkg::SAMPLE_W-1:0] rate,
                              input bit typed, input tick_result_type typed_want);
      bit              pause;
      tick_result_type predicted;
      @(negedge clock);
      pause = 1'b1;
      while (pause) begin
         if (tx_calm > 0) begin
            tx_calm--;
            pause = 1'b0;
         end else if ($urandom_range(99) < 2) begin
            tx_calm = $urandom_range(40, 10);
            pause = 1'b0;
         end else
            pause = ($urandom_range(99) < tx_idle_pct);
         if (pause) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_rate_sample <= rate;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = advance_revolutions(rate);
      awaited_results.push_back(typed ? typed_want : predicted);
      samples_sent++;
   endtask

   // stop sending and wait until every owed result has come back
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [grc_pkg::CSR_IDX_W-1:0] index,
                            input logic [grc_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         grc_pkg::CSR_DEADBAND:   settings.deadband   = data[grc_pkg::DEADBAND_W-1:0];
         grc_pkg::CSR_TURN_UNITS: settings.turn_units = data[grc_pkg::TURN_W-1:0];
         grc_pkg::CSR_LED_HOLD:   settings.led_hold   = data[grc_pkg::HOLD_W-1:0];
         default: ;                               // nothing behind this index
      endcase
      writes_done++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver side: ready changes on the falling edge only
   always @(negedge clock) begin
      if (rx_calm > 0) begin
         rx_calm--;
         rsp_ready <= 1'b1;
      end else begin
         if ($urandom_range(99) < 2)
            rx_calm = $urandom_range(40, 10);
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // result checker: every taken result against the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen.revs = rsp_revolution_count;
         seen.turn = rsp_turn_event;
         seen.leds = rsp_led_pattern;
         if (seen.turn == grc_pkg::EVENT_FWD)
            fwd_turns++;
         else if (seen.turn == grc_pkg::EVENT_BWD)
            bwd_turns++;
         if (awaited_results.size() == 0) begin
            if (mismatches < 10)
               $display("result %0d with nothing owed: count %0d event %0d leds %b",
                        results_seen, seen.revs, seen.turn, seen.leds);
            mismatches++;
         end else begin
            want = awaited_results.pop_front();
            if (seen.revs !== want.revs || seen.turn !== want.turn
                || seen.leds !== want.leds) begin
               if (mismatches < 10) begin
                  $display("result %0d: expected count %0d event %0d leds %b",
                           results_seen, want.revs, want.turn, want.leds);
                  $display("   got count %0d event %0d leds %b",
                           seen.revs, seen.turn, seen.leds);
               end
               mismatches++;
            end
         end
         results_seen++;
      end
   end

   // watchdog: a hung handshake ends the run
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("timeout: no item moved for %0d cycles, %0d results owed",
               STALL_LIMIT, awaited_results.size());
      $display("FAIL gyro_revolution_counter");
      $finish;
   end

   // main sequence: reset, directed plan, then the random phases
   initial begin
      int                                  row;
      int                                  phase;
      int                                  n;
      int                                  pick;
      int                                  mag;
      int                                  db;
      int                                  tu;
      int                                  hd;
      bit                                  run_backward;
      logic signed [grc_pkg::SAMPLE_W-1:0] rate;

      // every input known from time zero
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_rate_sample = '0;
      rsp_ready       = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = grc_pkg::CSR_DEADBAND;
      csr_data        = '0;
      tx_calm         = 0;
      rx_calm         = 0;
      mismatches      = 0;
      samples_sent    = 0;
      results_seen    = 0;
      writes_done     = 0;
      fwd_turns       = 0;
      bwd_turns       = 0;
      run_backward    = 1'b0;
      set_idling(0);

      // model state as it is after reset
      settings.deadband   = grc_pkg::DEADBAND_RESET;
      settings.turn_units = grc_pkg::TURN_UNITS_RESET;
      settings.led_hold   = grc_pkg::LED_HOLD_RESET;
      angle_units = '0;
      revs_net    = '0;
      chase_pos   = grc_pkg::LED_DARK;
      hold_ticks  = '0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed plan; writes only once the block has gone quiet
      for (row = 0; row < PLAN_ROWS; row++) begin
         if (PLAN[row].kind == STEP_WRITE) begin
            drain_results();
            write_reg(PLAN[row].index, PLAN[row].data);
         end else
            send_sample(PLAN[row].rate, PLAN[row].kind == STEP_TYPED, PLAN[row].want);
      end

      // random phases: three per idling mode, each with its own settings
      for (phase = 0; phase < PHASES; phase++) begin
         drain_results();
         set_idling(phase / 3);
         case (phase)
            0: begin                              // lowest extremes
               db = 0;
               tu = 32768;
               hd = 0;
            end
            3: begin                              // highest extremes
               db = 32767;
               tu = 1048575;
               hd = 1023;
            end
            5: begin                              // back to the reset values
               db = grc_pkg::DEADBAND_RESET;
               tu = grc_pkg::TURN_UNITS_RESET;
               hd = grc_pkg::LED_HOLD_RESET;
            end
            2, 7: begin                           // turn size below its normal range
               db = $urandom_range(300);
               tu = $urandom_range(3000);
               hd = $urandom_range(8);
            end
            default: begin
               db = $urandom_range(600);
               tu = $urandom_range(262144, 32768);
               hd = (phase == 8) ? $urandom_range(1023) : $urandom_range(40);
            end
         endcase
         // spare upper data bits are random, the register keeps only its width
         write_reg(grc_pkg::CSR_DEADBAND, {5'($urandom), 15'(db)});
         write_reg(grc_pkg::CSR_TURN_UNITS, 20'(tu));
         write_reg(grc_pkg::CSR_LED_HOLD, {10'($urandom), 10'(hd)});
         if (phase == 2 || phase == 6)
            write_reg(CSR_UNUSED, 20'($urandom));

         for (n = 0; n < PHASE_ITEMS; n++) begin
            // mid-phase the sender holds off until the block is empty
            if (n == PHASE_ITEMS / 2)
               drain_results();
            // mostly long runs in one direction so turns keep coming
            if ($urandom_range(99) < 3)
               run_backward = !run_backward;
            pick = $urandom_range(99);
            if (pick < 8)
               rate = 16'($urandom);
            else if (pick < 12) begin
               case ($urandom_range(3))
                  0: rate = 16'sh8000;
                  1: rate = 16'sh7FFF;
                  2: rate = 16'sh8001;
                  default: rate = '0;
               endcase
            end else begin
               if (pick < 25) begin                // around the deadband edge
                  mag = int'(settings.deadband) + int'($urandom_range(2)) - 1;
                  if (mag < 0)
                     mag = 0;
                  run_backward = ($urandom_range(1) == 1) ? !run_backward : run_backward;
               end else
                  mag = $urandom_range(32767, (settings.deadband > 15'd32766) ? 32767
                                              : int'(settings.deadband) + 1);
               rate = run_backward ? 16'(-mag) : 16'(mag);
            end
            send_sample(rate, 1'b0, QUIET);
         end
      end

      drain_results();
      // a few more edges so that any stray result would still be caught
      repeat (4) @(posedge clock);

      $display("%0d samples and %0d register writes, %0d forward and %0d backward turns seen",
               samples_sent, writes_done, fwd_turns, bwd_turns);
      $display("settings swept from the extremes to a below-range turn size, %0d mismatches",
               mismatches);
      if (mismatches == 0)
         $display("PASS gyro_revolution_counter");
      else
         $display("FAIL gyro_revolution_counter");
      $finish;
   end

endmodule
